FILE: rtl/lfuctp_pkg.sv
// Shared types and constants for the LFU cache tag policy block.
package lfuctp_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int FILL_BITS  = $clog2(ENTRIES + 1);
    localparam int CAP_BITS   = 7;
    localparam int TOTAL_BITS = 32;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

    // Lookup token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [IDX_BITS-1:0]   f_idx;
        logic [IDX_BITS-1:0]   f_rank;
        logic                  b_valid;
        logic [COUNT_BITS-1:0] b_count;
        logic [IDX_BITS-1:0]   b_rank;
        logic [IDX_BITS-1:0]   b_idx;
        logic [KEY_BITS-1:0]   b_key;
    } t_token;

    // Update broadcast to every cell once the decision is made.
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic                  age_all;
        logic [IDX_BITS-1:0]   slot;
        logic [IDX_BITS-1:0]   limit;
        logic [FILL_BITS-1:0]  filled;
        logic [KEY_BITS-1:0]   key;
    } t_upd;

endpackage

FILE: rtl/lfuctp_cell.sv
// One slot of the tag store: key, use count and recency rank.
module lfuctp_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lfuctp_pkg::IDX_BITS-1:0]  i_index,
    input  logic [lfuctp_pkg::FILL_BITS-1:0] i_filled,
    input  logic [lfuctp_pkg::KEY_BITS-1:0]  i_key,
    input  lfuctp_pkg::t_token            i_tok,
    input  lfuctp_pkg::t_upd              i_upd,
    output lfuctp_pkg::t_token            o_tok
);

    logic [lfuctp_pkg::KEY_BITS-1:0]   r_key;
    logic [lfuctp_pkg::COUNT_BITS-1:0] r_count;
    logic [lfuctp_pkg::IDX_BITS-1:0]   r_rank;
    lfuctp_pkg::t_token                r_tok;
    lfuctp_pkg::t_token                n_tok;
    logic                              filled;
    logic                              better;

    assign filled = {1'b0, i_index} < i_filled;
    assign better = !i_tok.b_valid || (r_count < i_tok.b_count) ||
                    ((r_count == i_tok.b_count) && (r_rank > i_tok.b_rank));

    // Fold this slot into the passing token: first match and best victim.
    always_comb begin
        n_tok = i_tok;
        if (filled && !i_tok.found && (r_key == i_key)) begin
            n_tok.found  = 1'b1;
            n_tok.f_idx  = i_index;
            n_tok.f_rank = r_rank;
        end
        if (filled && better) begin
            n_tok.b_valid = 1'b1;
            n_tok.b_count = r_count;
            n_tok.b_rank  = r_rank;
            n_tok.b_idx   = i_index;
            n_tok.b_key   = r_key;
        end
    end

    // Hand the token on; reset flushes any token in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Apply the broadcast update to this slot.
    always_ff @(posedge i_clk) begin
        if (i_upd.valid) begin
            if (i_upd.slot == i_index) begin
                r_rank <= '0;
                if (i_upd.hit) begin
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                end else begin
                    r_key   <= i_upd.key;
                    r_count <= lfuctp_pkg::COUNT_BITS'(1);
                end
            end else if (({1'b0, i_index} < i_upd.filled) &&
                         (i_upd.age_all || (r_rank < i_upd.limit))) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/lfu_cache_tag_policy_core.sv
// Top level of the LFU cache tag policy block.
// Usage: a request carries one key on i_key with i_valid; it is taken at a
// clock edge where i_valid is high and o_stall is low. Exactly one result
// follows on o_hit, o_slot, o_evicted, o_evicted_key and o_hit_total with
// o_valid, taken when i_stall is low.
// Each request walks a row of 64 slot cells, one cell per cycle, collecting
// the first key match and the least frequently used, least recent victim.
// The token leaving the last cell is captured; the update step broadcasts
// the update to all cells and loads the result register, which raises
// o_valid. A new request is not accepted until the update of the last one
// is committed and the block is idle again. A waiting result
// does not block the next request; a second result waits in the update step
// while the receiver stalls.
// The capacity register is written via i_cfg_valid / o_cfg_ready (always
// ready) and should only change while the block is idle.
// Synchronous active-low reset empties the store, clears the hit total and
// sets capacity to 64. Slot contents need no clearing: only filled slots
// are ever looked at.
module lfu_cache_tag_policy_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lfuctp_pkg::KEY_BITS-1:0]     i_key,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [lfuctp_pkg::IDX_BITS-1:0]     o_slot,
    output logic                                o_evicted,
    output logic [lfuctp_pkg::KEY_BITS-1:0]     o_evicted_key,
    output logic [lfuctp_pkg::TOTAL_BITS-1:0]   o_hit_total,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfuctp_pkg::CAP_BITS-1:0]     i_cfg_capacity
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                                 r_state;
    t_state                                 n_state;
    logic [lfuctp_pkg::KEY_BITS-1:0]        r_key;
    logic [lfuctp_pkg::FILL_BITS-1:0]       r_filled;
    logic [lfuctp_pkg::CAP_BITS-1:0]        r_cap;
    logic [lfuctp_pkg::TOTAL_BITS-1:0]      r_total;
    logic                                   r_out_valid;
    logic                                   r_hit;
    logic [lfuctp_pkg::IDX_BITS-1:0]        r_slot;
    logic                                   r_evicted;
    logic [lfuctp_pkg::KEY_BITS-1:0]        r_ev_key;
    lfuctp_pkg::t_token                     r_dec;

    lfuctp_pkg::t_token                     tok [lfuctp_pkg::ENTRIES+1];
    lfuctp_pkg::t_token                     tok_last;
    lfuctp_pkg::t_upd                       upd;
    logic [lfuctp_pkg::KEY_BITS-1:0]        scan_key;
    logic                                   accept;
    logic                                   commit;
    logic [lfuctp_pkg::FILL_BITS-1:0]       cap_eff;
    logic                                   full;

    assign accept      = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign commit      = (r_state == S_UPD) && !(r_out_valid && i_stall);
    assign tok_last    = tok[lfuctp_pkg::ENTRIES];

    // The first cell sees the key in the cycle it is accepted.
    assign scan_key    = accept ? i_key : r_key;

    // Clamp the capacity to the range 1 .. ENTRIES.
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = lfuctp_pkg::FILL_BITS'(1);
        end else if (32'(r_cap) > 32'(lfuctp_pkg::ENTRIES)) begin
            cap_eff = lfuctp_pkg::FILL_BITS'(lfuctp_pkg::ENTRIES);
        end else begin
            cap_eff = lfuctp_pkg::FILL_BITS'(r_cap);
        end
    end
    assign full = r_filled >= cap_eff;

    // Token entering the first cell.
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = accept;
    end

    // Row of slot cells.
    for (genvar g = 0; g < lfuctp_pkg::ENTRIES; g++) begin : g_cell
        lfuctp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (lfuctp_pkg::IDX_BITS'(g)),
            .i_filled (r_filled),
            .i_key    (scan_key),
            .i_tok    (tok[g]),
            .i_upd    (upd),
            .o_tok    (tok[g+1])
        );
    end

    // Hold the finished token until the update is committed.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && tok_last.valid) begin
            r_dec <= tok_last;
        end
    end

    // Replacement decision, broadcast to the cells on commit.
    always_comb begin
        upd         = '0;
        upd.valid   = commit;
        upd.filled  = r_filled;
        upd.key     = r_key;
        if (r_dec.found) begin
            upd.hit   = 1'b1;
            upd.slot  = r_dec.f_idx;
            upd.limit = r_dec.f_rank;
        end else if (!full) begin
            upd.age_all = 1'b1;
            upd.slot    = r_filled[lfuctp_pkg::IDX_BITS-1:0];
        end else begin
            upd.slot  = r_dec.b_idx;
            upd.limit = r_dec.b_rank;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (tok_last.valid) n_state = S_UPD;
            end
            S_UPD: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_cap       <= lfuctp_pkg::CAP_RESET;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_capacity;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                if (r_dec.found) begin
                    r_total <= r_total + 1'b1;
                end else if (!full) begin
                    r_filled <= r_filled + 1'b1;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request key and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_key;
        end
        if (commit) begin
            r_hit     <= r_dec.found;
            r_slot    <= upd.slot;
            r_evicted <= !r_dec.found && full;
            r_ev_key  <= (!r_dec.found && full) ? r_dec.b_key : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_slot        = r_slot;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_ev_key;
    assign o_hit_total   = r_total;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_last.valid |-> (r_state == S_SCAN)) else $error("token outside scan");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_filled) <= 32'(lfuctp_pkg::ENTRIES)) else $error("fill overflow");
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !r_dec.found && full) |-> r_dec.b_valid)
        else $error("eviction without victim");
`endif

endmodule
